[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL. Empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property at every clock edge outside reset.
`define CWC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check that a condition implies another one in the next cycle.
`define CWC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CWC_ASSERT(lbl, clk, rstn, prop, msg)
`define CWC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[hdl/cwc_pkg.sv]
package cwc_pkg;

    // Event codes
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_ACK    = 3'd1;
    localparam logic [2:0] OP_LOSS   = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_RTT    = 3'd4;
    localparam logic [2:0] OP_RESEND = 3'd5;
    localparam logic [2:0] OP_RECV   = 3'd6;

    localparam int CWC_TIME_BITS  = 48;
    localparam int CWC_DELAY_BITS = 18;

    localparam logic [10:0] WIN_DEFAULT  = 11'd32;
    localparam logic [10:0] WIN_MAX_LOW  = 11'd512;
    localparam logic [10:0] WIN_MAX_MID  = 11'd1024;
    localparam logic [10:0] WIN_MAX_HIGH = 11'd1280;
    localparam logic [10:0] WIN_MAX_TOP  = 11'd1536;
    localparam logic [10:0] WIN_STEP_MIN = 11'd8;
    localparam logic [7:0]  FLOOR_DEFAULT = 8'd32;
    localparam logic [7:0]  FLOOR_TIERED  = 8'd128;
    localparam logic [15:0] RTT_DEFAULT  = 16'd50;
    localparam logic [15:0] DEV_DEFAULT  = 16'd25;
    localparam logic [15:0] RTT_FLOOR    = 16'd10;
    localparam logic [15:0] DEV_FLOOR    = 16'd5;
    localparam logic [CWC_DELAY_BITS-1:0] PERIOD_MIN = 18'd100;
    localparam logic [31:0] SLOW_START_PERIODS = 32'd10;

    typedef struct packed {
        logic [15:0] srtt;
        logic [15:0] dev;
    } t_cwc_rtt;

    typedef struct packed {
        logic [10:0] send_window;
        logic [15:0] rtt_estimate;
        logic [15:0] rtt_variation;
        logic        in_slow_start;
        logic        period_elapsed;
    } t_cwc_res;

    // Window maximum tier for an RTT value
    function automatic logic [10:0] cwc_pick_max(input logic [15:0] r);
        logic [10:0] m;
        if (r < 16'd10) begin
            m = WIN_MAX_LOW;
        end else if (r < 16'd50) begin
            m = WIN_MAX_MID;
        end else if (r < 16'd100) begin
            m = WIN_MAX_HIGH;
        end else if (r <= 16'd200) begin
            m = WIN_MAX_TOP;
        end else begin
            m = WIN_MAX_MID;
        end
        return m;
    endfunction

endpackage

[hdl/cwc_rtt.sv]
module cwc_rtt (
    input  logic [15:0]        i_srtt,
    input  logic [15:0]        i_dev,
    input  logic               i_first,
    input  logic [15:0]        i_sample,
    output cwc_pkg::t_cwc_rtt  o_rtt
);
    import cwc_pkg::*;

    logic [15:0] diff;
    logic [17:0] dev_sum;
    logic [18:0] srtt_sum;
    logic [15:0] srtt_raw;
    logic [15:0] dev_raw;

    // Smooth deviation by 3/4 and RTT by 7/8
    always_comb begin
        diff     = (i_srtt > i_sample) ? (i_srtt - i_sample) : (i_sample - i_srtt);
        dev_sum  = ({2'b00, i_dev} << 1) + {2'b00, i_dev} + {2'b00, diff};
        srtt_sum = ({3'b000, i_srtt} << 3) - {3'b000, i_srtt} + {3'b000, i_sample};
        if (i_first) begin
            srtt_raw = i_sample;
            dev_raw  = i_sample >> 1;
        end else begin
            srtt_raw = srtt_sum[18:3];
            dev_raw  = dev_sum[17:2];
        end
        // Clamp to the floors
        o_rtt.srtt = (srtt_raw < RTT_FLOOR) ? RTT_FLOOR : srtt_raw;
        o_rtt.dev  = (dev_raw < DEV_FLOOR) ? DEV_FLOOR : dev_raw;
    end

endmodule

[hdl/cwc_core.sv]
module cwc_core #(
    parameter int TIME_BITS = cwc_pkg::CWC_TIME_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [2:0]            i_operation,
    input  logic [63:0]           i_ack_seq,
    input  logic [TIME_BITS-1:0]  i_now_ms,
    input  logic [15:0]           i_rtt_sample_ms,
    input  logic [15:0]           i_recv_amount,
    output cwc_pkg::t_cwc_res     o_result
);
    import cwc_pkg::*;

    logic [10:0]          r_window,  n_window;
    logic [10:0]          r_win_max, n_win_max;
    logic [10:0]          r_win_min, n_win_min;
    logic [7:0]           r_floor,   n_floor;
    logic [15:0]          r_srtt,    n_srtt;
    logic [15:0]          r_dev,     n_dev;
    logic [63:0]          r_last_acked, n_last_acked;
    logic [31:0]          r_recv_total, n_recv_total;
    logic [31:0]          r_resend_total, n_resend_total;
    logic [31:0]          r_period_count, n_period_count;
    logic [TIME_BITS-1:0] r_last_time, n_last_time;
    logic                 r_slow_start, n_slow_start;
    logic                 r_first_rtt,  n_first_rtt;

    t_cwc_rtt             rtt_upd;
    logic                 ran;
    logic [63:0]          span;
    logic [10:0]          room;
    logic [CWC_DELAY_BITS-1:0] delay4;
    logic [CWC_DELAY_BITS-1:0] delay;
    logic [TIME_BITS-1:0] elapsed;
    logic [31:0]          pc_inc;
    logic [10:0]          max_p;
    logic [10:0]          step;
    logic [11:0]          grown;
    logic [10:0]          cut;

    cwc_rtt u_rtt (
        .i_srtt   (r_srtt),
        .i_dev    (r_dev),
        .i_first  (r_first_rtt),
        .i_sample (i_rtt_sample_ms),
        .o_rtt    (rtt_upd)
    );

    // Shared helper terms for ack and period handling
    always_comb begin
        span    = i_ack_seq - r_last_acked;
        room    = r_win_max - ((r_window < r_win_max) ? r_window : r_win_max);
        delay4  = {r_srtt, 2'b00};
        delay   = (delay4 < PERIOD_MIN) ? PERIOD_MIN : delay4;
        elapsed = i_now_ms - r_last_time;
        pc_inc  = r_period_count + 32'd1;
        max_p   = (pc_inc[1:0] == 2'b00) ? cwc_pick_max(r_srtt) : r_win_max;
        step    = ((r_window >> 3) < WIN_STEP_MIN) ? WIN_STEP_MIN : (r_window >> 3);
        grown   = {1'b0, r_window} + {1'b0, step};
        cut     = r_window - (r_window >> 2);
    end

    // Apply one event to the state
    always_comb begin
        n_window       = r_window;
        n_win_max      = r_win_max;
        n_win_min      = r_win_min;
        n_floor        = r_floor;
        n_srtt         = r_srtt;
        n_dev          = r_dev;
        n_last_acked   = r_last_acked;
        n_recv_total   = r_recv_total;
        n_resend_total = r_resend_total;
        n_period_count = r_period_count;
        n_last_time    = r_last_time;
        n_slow_start   = r_slow_start;
        n_first_rtt    = r_first_rtt;
        ran            = 1'b0;
        unique case (i_operation)
            OP_INIT: begin
                n_window       = WIN_DEFAULT;
                n_win_max      = WIN_DEFAULT;
                n_win_min      = WIN_DEFAULT;
                n_floor        = FLOOR_DEFAULT;
                n_srtt         = RTT_DEFAULT;
                n_dev          = DEV_DEFAULT;
                n_last_acked   = i_ack_seq;
                n_recv_total   = '0;
                n_resend_total = '0;
                n_period_count = '0;
                n_last_time    = i_now_ms;
                n_slow_start   = 1'b1;
                n_first_rtt    = 1'b1;
            end
            OP_ACK: begin
                if (i_ack_seq > r_last_acked) begin
                    if (r_slow_start) begin
                        if (r_window >= r_win_max || span >= {53'd0, room}) begin
                            n_slow_start = 1'b0;
                            n_window     = r_win_max;
                        end else begin
                            n_window = r_window + span[10:0];
                        end
                    end
                    n_last_acked = i_ack_seq;
                end
            end
            OP_LOSS: begin
                n_slow_start = 1'b0;
            end
            OP_TICK: begin
                if (i_now_ms >= r_last_time &&
                    elapsed >= {{(TIME_BITS-CWC_DELAY_BITS){1'b0}}, delay}) begin
                    ran            = 1'b1;
                    n_last_time    = i_now_ms;
                    n_period_count = pc_inc;
                    n_win_max      = max_p;
                    if (pc_inc[1:0] == 2'b00) begin
                        n_floor = FLOOR_TIERED;
                    end
                    if (r_slow_start) begin
                        if (pc_inc > SLOW_START_PERIODS) begin
                            n_slow_start = 1'b0;
                        end
                    end else begin
                        // Grow on few resends, cut on many
                        if ((r_recv_total >> 4) > r_resend_total) begin
                            n_window = (grown > {1'b0, max_p}) ? max_p : grown[10:0];
                        end else if ((r_recv_total >> 2) < r_resend_total) begin
                            n_window = (cut < r_win_min) ? r_win_min : cut;
                            if (n_window < {3'b000, n_floor}) begin
                                n_win_min = {3'b000, n_floor};
                            end
                        end
                        n_recv_total   = '0;
                        n_resend_total = '0;
                    end
                end
            end
            OP_RTT: begin
                if (r_win_max == WIN_DEFAULT) begin
                    n_win_max = cwc_pick_max(i_rtt_sample_ms);
                    n_floor   = FLOOR_TIERED;
                end
                n_first_rtt = 1'b0;
                n_srtt      = rtt_upd.srtt;
                n_dev       = rtt_upd.dev;
            end
            OP_RESEND: begin
                n_resend_total = r_resend_total + 32'd1;
            end
            OP_RECV: begin
                n_recv_total = r_recv_total + {16'd0, i_recv_amount};
            end
            default: begin
            end
        endcase
    end

    // Hold state between events
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window       <= WIN_DEFAULT;
            r_win_max      <= WIN_DEFAULT;
            r_win_min      <= WIN_DEFAULT;
            r_floor        <= FLOOR_DEFAULT;
            r_srtt         <= RTT_DEFAULT;
            r_dev          <= DEV_DEFAULT;
            r_last_acked   <= '0;
            r_recv_total   <= '0;
            r_resend_total <= '0;
            r_period_count <= '0;
            r_last_time    <= '0;
            r_slow_start   <= 1'b1;
            r_first_rtt    <= 1'b1;
        end else if (i_fire) begin
            r_window       <= n_window;
            r_win_max      <= n_win_max;
            r_win_min      <= n_win_min;
            r_floor        <= n_floor;
            r_srtt         <= n_srtt;
            r_dev          <= n_dev;
            r_last_acked   <= n_last_acked;
            r_recv_total   <= n_recv_total;
            r_resend_total <= n_resend_total;
            r_period_count <= n_period_count;
            r_last_time    <= n_last_time;
            r_slow_start   <= n_slow_start;
            r_first_rtt    <= n_first_rtt;
        end
    end

    // Report the state after the event
    always_comb begin
        o_result.send_window    = n_window;
        o_result.rtt_estimate   = n_srtt;
        o_result.rtt_variation  = n_dev;
        o_result.in_slow_start  = n_slow_start;
        o_result.period_elapsed = ran;
    end

endmodule

[hdl/congestion_window_controller.sv]
// Congestion-window controller: one request per event (init, ack, loss, timer
// tick, RTT sample, resend, received add) and one result per request carrying
// the window, smoothed RTT, RTT variation, slow-start flag and whether a tick
// ran an adjustment period. A request is registered on entry, applied to the
// state as its result lands in the output register, and a new request is
// taken every cycle while the output drains. While a result waits in the
// output register, the input register still takes one more request; the input
// side stalls only once both registers are full.
`include "assert_macros.svh"
module congestion_window_controller #(
    parameter int TIME_BITS = cwc_pkg::CWC_TIME_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_operation,
    input  logic [63:0]           i_ack_seq,
    input  logic [TIME_BITS-1:0]  i_now_ms,
    input  logic [15:0]           i_rtt_sample_ms,
    input  logic [15:0]           i_recv_amount,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [10:0]           o_send_window,
    output logic [15:0]           o_rtt_estimate,
    output logic [15:0]           o_rtt_variation,
    output logic                  o_in_slow_start,
    output logic                  o_period_elapsed
);
    import cwc_pkg::*;

    logic                 r_in_vld;
    logic [2:0]           r_operation;
    logic [63:0]          r_ack_seq;
    logic [TIME_BITS-1:0] r_now_ms;
    logic [15:0]          r_rtt_sample_ms;
    logic [15:0]          r_recv_amount;
    logic                 r_out_vld;
    t_cwc_res             r_result;
    t_cwc_res             result;
    logic                 advance;
    logic                 fire;

    // Move the output stage when it is empty or being drained
    assign advance = !r_out_vld || i_ready;
    assign fire    = r_in_vld && advance;
    assign o_ready = !r_in_vld || advance;

    // Capture a request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_operation     <= i_operation;
            r_ack_seq       <= i_ack_seq;
            r_now_ms        <= i_now_ms;
            r_rtt_sample_ms <= i_rtt_sample_ms;
            r_recv_amount   <= i_recv_amount;
        end
    end

    cwc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_operation     (r_operation),
        .i_ack_seq       (r_ack_seq),
        .i_now_ms        (r_now_ms),
        .i_rtt_sample_ms (r_rtt_sample_ms),
        .i_recv_amount   (r_recv_amount),
        .o_result        (result)
    );

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_send_window    = r_result.send_window;
    assign o_rtt_estimate   = r_result.rtt_estimate;
    assign o_rtt_variation  = r_result.rtt_variation;
    assign o_in_slow_start  = r_result.in_slow_start;
    assign o_period_elapsed = r_result.period_elapsed;

    `CWC_ASSERT(a_win_cap, i_clk, i_rst_n, !o_valid || (o_send_window <= WIN_MAX_TOP), "window above cap")
    `CWC_ASSERT(a_rtt_floor, i_clk, i_rst_n, !o_valid || (o_rtt_estimate >= RTT_FLOOR), "rtt below floor")
    `CWC_ASSERT(a_dev_floor, i_clk, i_rst_n, !o_valid || (o_rtt_variation >= DEV_FLOOR), "variation below floor")
    `CWC_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_vld && !advance, r_in_vld && r_out_vld, "stalled request lost")
    `CWC_ASSERT_NEXT(a_fire_out, i_clk, i_rst_n, fire, r_out_vld, "result not registered")

endmodule

[test/cwc_window_checker.sv]
// Watch both channels of the congestion-window controller, predict the report
// for every accepted request and compare it with the report that comes out.
module cwc_window_checker #(
    parameter int TIME_BITS = cwc_pkg::CWC_TIME_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [2:0]            i_operation,
    input  logic [63:0]           i_ack_seq,
    input  logic [TIME_BITS-1:0]  i_now_ms,
    input  logic [15:0]           i_rtt_sample_ms,
    input  logic [15:0]           i_recv_amount,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [10:0]           i_send_window,
    input  logic [15:0]           i_rtt_estimate,
    input  logic [15:0]           i_rtt_variation,
    input  logic                  i_in_slow_start,
    input  logic                  i_period_elapsed,
    output int                    o_mismatches,
    output int                    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import cwc_pkg::*;

    // Predicted controller state
    logic [10:0]          cwnd;
    logic [10:0]          cwnd_max;
    logic [10:0]          cwnd_min;
    logic [7:0]           floor_limit;
    logic [15:0]          srtt;
    logic [15:0]          rttvar;
    logic [63:0]          acked_seq;
    logic [31:0]          recv_count;
    logic [31:0]          resend_count;
    logic [31:0]          periods_run;
    logic [TIME_BITS-1:0] period_start_ms;
    logic                 ramp_active;
    logic                 awaiting_first_rtt;

    t_cwc_res window_reports[$];
    t_cwc_res due;
    int       fault_count = 0;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    function automatic void restore_defaults();
        cwnd               = WIN_DEFAULT;
        cwnd_max           = WIN_DEFAULT;
        cwnd_min           = WIN_DEFAULT;
        floor_limit        = FLOOR_DEFAULT;
        srtt               = RTT_DEFAULT;
        rttvar             = DEV_DEFAULT;
        acked_seq          = '0;
        recv_count         = '0;
        resend_count       = '0;
        periods_run        = '0;
        period_start_ms    = '0;
        ramp_active        = 1'b1;
        awaiting_first_rtt = 1'b1;
    endfunction

    // Pick the window ceiling from an RTT tier and raise the floor limit
    function automatic void set_tier(input logic [15:0] r);
        if (r < 16'd10) begin
            cwnd_max = WIN_MAX_LOW;
        end else if (r < 16'd50) begin
            cwnd_max = WIN_MAX_MID;
        end else if (r < 16'd100) begin
            cwnd_max = WIN_MAX_HIGH;
        end else if (r <= 16'd200) begin
            cwnd_max = WIN_MAX_TOP;
        end else begin
            cwnd_max = WIN_MAX_MID;
        end
        floor_limit = FLOOR_TIERED;
    endfunction

    // One adjustment period: grow by an eighth, cut by a quarter, or hold
    function automatic void close_period();
        logic [31:0] step;
        logic [31:0] grown;
        periods_run = periods_run + 32'd1;
        if (periods_run[1:0] == 2'b00) set_tier(srtt);
        if (ramp_active) begin
            if (periods_run > SLOW_START_PERIODS) ramp_active = 1'b0;
        end else begin
            if ((recv_count >> 4) > resend_count) begin
                step = {21'd0, cwnd >> 3};
                if (step < 32'd8) step = 32'd8;
                grown = {21'd0, cwnd} + step;
                if (grown > {21'd0, cwnd_max}) grown = {21'd0, cwnd_max};
                cwnd = grown[10:0];
            end else if ((recv_count >> 2) < resend_count) begin
                cwnd = cwnd - (cwnd >> 2);
                if (cwnd < cwnd_min) cwnd = cwnd_min;
                if (cwnd < {3'b000, floor_limit}) cwnd_min = {3'b000, floor_limit};
            end
            recv_count   = '0;
            resend_count = '0;
        end
    endfunction

    // Apply one request to the predicted state and return the expected report
    function automatic t_cwc_res next_window_report(
        input logic [2:0]           op,
        input logic [63:0]          seq,
        input logic [TIME_BITS-1:0] now,
        input logic [15:0]          sample,
        input logic [15:0]          amount
    );
        t_cwc_res    rep;
        logic [63:0] span;
        logic [63:0] room;
        logic [63:0] delay;
        logic [31:0] gap_diff;
        logic [31:0] next_dev;
        logic [31:0] next_srtt;
        logic        ticked;
        ticked = 1'b0;
        case (op)
            OP_INIT: begin
                restore_defaults();
                acked_seq       = seq;
                period_start_ms = now;
            end
            OP_ACK: begin
                if (seq > acked_seq) begin
                    span = seq - acked_seq;
                    if (ramp_active) begin
                        room = {53'd0, cwnd_max - ((cwnd < cwnd_max) ? cwnd : cwnd_max)};
                        if (cwnd >= cwnd_max || span >= room) begin
                            ramp_active = 1'b0;
                            cwnd        = cwnd_max;
                        end else begin
                            cwnd = cwnd + span[10:0];
                        end
                    end
                    acked_seq = seq;
                end
            end
            OP_LOSS: ramp_active = 1'b0;
            OP_TICK: begin
                delay = {48'd0, srtt} << 2;
                if (delay < 64'd100) delay = 64'd100;
                if (now >= period_start_ms && (now - period_start_ms) >= delay) begin
                    close_period();
                    period_start_ms = now;
                    ticked          = 1'b1;
                end
            end
            OP_RTT: begin
                if (cwnd_max == WIN_DEFAULT) set_tier(sample);
                if (awaiting_first_rtt) begin
                    awaiting_first_rtt = 1'b0;
                    srtt               = sample;
                    rttvar             = sample >> 1;
                end else begin
                    gap_diff  = {16'd0, (srtt > sample) ? srtt - sample : sample - srtt};
                    next_dev  = ({16'd0, rttvar} * 32'd3 + gap_diff) >> 2;
                    next_srtt = ({16'd0, srtt} * 32'd7 + {16'd0, sample}) >> 3;
                    rttvar    = next_dev[15:0];
                    srtt      = next_srtt[15:0];
                end
                if (srtt < RTT_FLOOR) srtt = RTT_FLOOR;
                if (rttvar < DEV_FLOOR) rttvar = DEV_FLOOR;
            end
            OP_RESEND: resend_count = resend_count + 32'd1;
            OP_RECV:   recv_count = recv_count + {16'd0, amount};
            default: ;
        endcase
        rep.send_window    = cwnd;
        rep.rtt_estimate   = srtt;
        rep.rtt_variation  = rttvar;
        rep.in_slow_start  = ramp_active;
        rep.period_elapsed = ticked;
        return rep;
    endfunction

    function automatic void compare_field(
        input string           field,
        input longint unsigned want,
        input longint unsigned got
    );
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fault_count++;
        end
    endfunction

    // Retire results before queuing the new request of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_defaults();
            window_reports.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (window_reports.size() == 0) begin
                    $error("report with no request waiting: send_window %0d", i_send_window);
                    fault_count++;
                end else begin
                    due = window_reports.pop_front();
                    compare_field("send_window", due.send_window, i_send_window);
                    compare_field("rtt_estimate", due.rtt_estimate, i_rtt_estimate);
                    compare_field("rtt_variation", due.rtt_variation, i_rtt_variation);
                    compare_field("in_slow_start", due.in_slow_start, i_in_slow_start);
                    compare_field("period_elapsed", due.period_elapsed, i_period_elapsed);
                end
            end
            if (i_req_valid && i_req_ready) begin
                window_reports.push_back(next_window_report(i_operation, i_ack_seq, i_now_ms,
                                                            i_rtt_sample_ms, i_recv_amount));
            end
        end
        o_outstanding <= window_reports.size();
        o_mismatches  <= fault_count;
    end

endmodule

[test/congestion_window_controller_tb.sv]
// Drive congestion-window events into the controller and give the verdict;
// the checker beside the block predicts and compares every report.
module congestion_window_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cwc_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RANDOM_EVENTS = 1800;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam logic [CWC_TIME_BITS-1:0] NOW_MAX = '1;

    typedef enum int {MIX_GROW, MIX_CUT, MIX_EVEN, MIX_HOLD} t_traffic_mix;
    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_CYCLIC} t_drain_pace;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     req_valid     = 1'b0;
    logic                     req_ready;
    logic [2:0]               operation     = '0;
    logic [63:0]              ack_seq       = '0;
    logic [CWC_TIME_BITS-1:0] now_ms        = '0;
    logic [15:0]              rtt_sample_ms = '0;
    logic [15:0]              recv_amount   = '0;
    logic                     res_valid;
    logic                     res_ready     = 1'b0;
    logic [10:0]              send_window;
    logic [15:0]              rtt_estimate;
    logic [15:0]              rtt_variation;
    logic                     in_slow_start;
    logic                     period_elapsed;
    int                       mismatches;
    int                       outstanding;

    // Stimulus bookkeeping
    logic [63:0]              seq_cursor  = '0;
    logic [CWC_TIME_BITS-1:0] clock_ms    = '0;
    int                       burst_left  = 0;
    int                       events_sent = 0;
    t_traffic_mix             traffic     = MIX_EVEN;

    // Receiver pacing
    t_drain_pace              drain_pace  = READY_ALWAYS;
    int                       pace_left   = 0;
    int                       pace_phase  = 0;
    int                       cycle_len   = 2;
    int                       ready_len   = 1;

    int                       quiet_cycles = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    congestion_window_controller u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (req_valid),
        .o_ready          (req_ready),
        .i_operation      (operation),
        .i_ack_seq        (ack_seq),
        .i_now_ms         (now_ms),
        .i_rtt_sample_ms  (rtt_sample_ms),
        .i_recv_amount    (recv_amount),
        .o_valid          (res_valid),
        .i_ready          (res_ready),
        .o_send_window    (send_window),
        .o_rtt_estimate   (rtt_estimate),
        .o_rtt_variation  (rtt_variation),
        .o_in_slow_start  (in_slow_start),
        .o_period_elapsed (period_elapsed)
    );

    cwc_window_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_req_valid      (req_valid),
        .i_req_ready      (req_ready),
        .i_operation      (operation),
        .i_ack_seq        (ack_seq),
        .i_now_ms         (now_ms),
        .i_rtt_sample_ms  (rtt_sample_ms),
        .i_recv_amount    (recv_amount),
        .i_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .i_send_window    (send_window),
        .i_rtt_estimate   (rtt_estimate),
        .i_rtt_variation  (rtt_variation),
        .i_in_slow_start  (in_slow_start),
        .i_period_elapsed (period_elapsed),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding)
    );

    // Stall the result side on a random pattern that is redrawn when its run ends
    always @(negedge clk) begin
        if (pace_left == 0) begin
            drain_pace = t_drain_pace'($urandom_range(0, 3));
            pace_left  = $urandom_range(40, 160);
            cycle_len  = $urandom_range(2, 12);
            ready_len  = $urandom_range(1, cycle_len - 1);
        end else begin
            pace_left--;
        end
        pace_phase++;
        case (drain_pace)
            READY_ALWAYS: res_ready <= 1'b1;
            READY_COIN:   res_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: res_ready <= ($urandom_range(0, 3) == 0);
            default:      res_ready <= (pace_phase % cycle_len) < ready_len;
        endcase
    end

    // Stop the run if no request and no result moves for too long
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // RTT values on either side of each tier boundary
    function automatic logic [15:0] tier_edge(input int k);
        case (k)
            0:       return 16'd0;
            1:       return 16'd9;
            2:       return 16'd10;
            3:       return 16'd49;
            4:       return 16'd50;
            5:       return 16'd99;
            6:       return 16'd100;
            7:       return 16'd200;
            8:       return 16'd201;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [15:0] rtt_pick();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 15) return 16'($urandom_range(5, 260));
        if (pick < 19) return tier_edge($urandom_range(0, 9));
        return 16'($urandom);
    endfunction

    // Insert a gap once the current burst runs out
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 15);
            gap = $urandom_range(1, 8);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Present one request and hold it until accepted
    task automatic push_event(
        input logic [2:0]               op,
        input logic [63:0]              seq,
        input logic [CWC_TIME_BITS-1:0] now,
        input logic [15:0]              sample,
        input logic [15:0]              amount
    );
        @(negedge clk);
        req_valid     <= 1'b1;
        operation     <= op;
        ack_seq       <= seq;
        now_ms        <= now;
        rtt_sample_ms <= sample;
        recv_amount   <= amount;
        do @(posedge clk); while (!req_ready);
        if (op != OP_UNUSED) events_sent++;
        pace_sender();
    endtask

    // Restart the flow, usually followed by a first RTT sample
    task automatic restart_flow();
        logic [63:0] start_seq;
        if ($urandom_range(0, 3) == 0) clock_ms = CWC_TIME_BITS'(rand64() >> 18);
        start_seq  = ($urandom_range(0, 4) == 0) ? rand64() : 64'($urandom_range(0, 100000));
        seq_cursor = start_seq;
        push_event(OP_INIT, start_seq, clock_ms, 16'($urandom), 16'($urandom));
        if ($urandom_range(0, 9) < 7) begin
            push_event(OP_RTT, rand64(), CWC_TIME_BITS'(rand64()), rtt_pick(), 16'($urandom));
        end
    endtask

    task automatic random_event();
        int                       weight [8];
        int                       total;
        int                       pick;
        int                       chosen;
        logic [2:0]               op;
        logic [63:0]              seq;
        logic [CWC_TIME_BITS-1:0] now;
        logic [15:0]              sample;
        logic [15:0]              amount;
        weight[OP_INIT]   = 1;
        weight[OP_ACK]    = 25;
        weight[OP_LOSS]   = 1;
        weight[OP_TICK]   = 20;
        weight[OP_RTT]    = 8;
        weight[OP_RESEND] = 10;
        weight[OP_RECV]   = 10;
        weight[OP_UNUSED] = 1;
        case (traffic)
            MIX_GROW: begin
                weight[OP_RESEND] = 3;
                weight[OP_RECV]   = 20;
            end
            MIX_CUT: begin
                weight[OP_RESEND] = 20;
                weight[OP_RECV]   = 6;
            end
            MIX_HOLD: begin
                weight[OP_ACK]  = 4;
                weight[OP_TICK] = 30;
                weight[OP_LOSS] = 0;
            end
            default: weight[OP_LOSS] = 2;
        endcase
        total = 0;
        foreach (weight[k]) total += weight[k];
        pick   = $urandom_range(0, total - 1);
        chosen = 0;
        while (pick >= weight[chosen]) begin
            pick -= weight[chosen];
            chosen++;
        end
        op = chosen[2:0];

        // Fields an operation does not use carry noise
        seq    = rand64();
        now    = CWC_TIME_BITS'(rand64());
        sample = 16'($urandom);
        amount = 16'($urandom);
        case (op)
            OP_ACK: begin
                pick = $urandom_range(0, 19);
                if (pick < 14) begin
                    seq = seq_cursor + $urandom_range(1, 64);
                end else if (pick < 16) begin
                    seq = seq_cursor + $urandom_range(65, 3000);
                end else if (pick < 18) begin
                    seq = seq_cursor - $urandom_range(0, 100);
                end
                if (seq > seq_cursor) seq_cursor = seq;
            end
            OP_TICK: begin
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    clock_ms += $urandom_range(0, 250);
                end else if (pick < 95) begin
                    clock_ms += $urandom_range(250, 5000);
                end else if (pick < 99) begin
                    clock_ms += $urandom_range(5000, 300000);
                end
                now = (pick == 99) ? clock_ms - $urandom_range(1, 500) : clock_ms;
            end
            OP_RTT: sample = rtt_pick();
            OP_RECV: begin
                if ($urandom_range(0, 19) != 0) begin
                    case (traffic)
                        MIX_GROW: amount = 16'($urandom_range(200, 3000));
                        MIX_CUT:  amount = 16'($urandom_range(0, 20));
                        MIX_EVEN: amount = 16'($urandom_range(0, 400));
                        default:  amount = 16'($urandom_range(0, 1000));
                    endcase
                end
            end
            default: ;
        endcase
        if (op == OP_INIT) begin
            restart_flow();
        end else begin
            push_event(op, seq, now, sample, amount);
        end
    endtask

    initial begin
        int target;
        int mix_left;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Unused code, stale and full-range acks out of reset
        push_event(OP_UNUSED, '1, '1, '1, '1);
        push_event(OP_ACK, 64'd0, '0, '0, '0);
        push_event(OP_ACK, '1, '0, '0, '0);
        // Extreme RTT samples and counter updates
        push_event(OP_INIT, 64'd0, '0, '0, '0);
        push_event(OP_RTT, '0, '0, 16'hFFFF, '0);
        push_event(OP_RTT, '0, '0, 16'd0, '0);
        push_event(OP_RESEND, '0, '0, '0, '0);
        push_event(OP_RECV, '0, '0, '0, 16'hFFFF);
        // Period at the top of the time range, then a tick that went backwards
        push_event(OP_INIT, 64'd5, NOW_MAX - 300, '0, '0);
        push_event(OP_RTT, '0, '0, 16'd9, '0);
        push_event(OP_TICK, '0, NOW_MAX, '0, '0);
        push_event(OP_TICK, '0, '0, '0, '0);
        // Slow-start growth, stale ack, loss
        push_event(OP_ACK, 64'd105, '0, '0, '0);
        push_event(OP_ACK, 64'd50, '0, '0, '0);
        push_event(OP_LOSS, '0, '0, '0, '0);
        // Tick short of the delay near the end of the time range
        push_event(OP_INIT, 64'd1, NOW_MAX - 50, '0, '0);
        push_event(OP_TICK, '0, NOW_MAX, '0, '0);
        // Ack span far beyond the room left saturates at the ceiling
        push_event(OP_RTT, '0, '0, 16'd150, '0);
        push_event(OP_ACK, '1, '0, '0, '0);
        // Start id at the top, so every ack is stale
        push_event(OP_INIT, '1, 48'd1000, '0, '0);
        push_event(OP_ACK, 64'd0, '0, '0, '0);
        push_event(OP_RTT, '0, '0, 16'd200, '0);
        push_event(OP_UNUSED, '0, '0, '0, '0);

        // Random traffic in phases of changing mix
        target   = events_sent + RANDOM_EVENTS;
        mix_left = 0;
        restart_flow();
        while (events_sent < target) begin
            if (mix_left == 0) begin
                traffic  = t_traffic_mix'($urandom_range(0, 3));
                mix_left = $urandom_range(20, 60);
            end
            mix_left--;
            random_event();
        end
        @(negedge clk);
        req_valid <= 1'b0;

        // Drain the pipeline, then give late results a chance to show up
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/cwc_pkg.sv
hdl/cwc_rtt.sv
hdl/cwc_core.sv
hdl/congestion_window_controller.sv
test/cwc_window_checker.sv
test/congestion_window_controller_tb.sv
